FILE: rtl/core/crp_pkg.sv
// Shared widths, reset values and status codes for the circle pair resolver.
// No dependencies; crp_if and the top level refer to it by scoped names.
package crp_pkg;

  localparam int POS_WIDTH_DEF = 24;
  localparam int RAD_W         = 16;
  localparam int MASS_W        = 16;
  localparam int DAMP_W        = 16;
  localparam int DAMP_FRAC     = 15;
  localparam logic [DAMP_W-1:0] DAMP_RESET = 16'd24576;

  localparam int SUM_W    = RAD_W + 1;
  localparam int SQ_W     = 2 * SUM_W;
  localparam int D2_W     = SQ_W + 1;
  localparam int ROOT_W   = (D2_W + 1) / 2;
  localparam int MSUM_W   = MASS_W + 1;
  localparam int PROD_W   = SUM_W + MASS_W;
  localparam int TERM_W   = PROD_W + DAMP_W;
  localparam int SHARE_QW = SUM_W + MASS_W;
  localparam int SHARE_NW = MSUM_W + SHARE_QW;
  localparam int MOVE_QW  = SHARE_QW - DAMP_FRAC + 1;
  localparam int MOVE_NW  = ROOT_W + MOVE_QW;
  localparam int MPROD_W  = SUM_W + SHARE_QW;
  localparam int MSUM2_W  = MOVE_NW + DAMP_FRAC;

  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_SEP  = 2'd1;
  localparam logic [1:0] ST_COIN = 2'd2;

endpackage

FILE: rtl/core/crp_if.sv
// Request channels of the circle pair resolver: pair input, result, damping write.
// Depends on crp_pkg for field widths.
interface crp_in_if #(parameter int POS_WIDTH = crp_pkg::POS_WIDTH_DEF);
  logic valid;
  logic ready;
  logic signed [POS_WIDTH-1:0] a_pos_x, a_pos_y, b_pos_x, b_pos_y;
  logic [crp_pkg::RAD_W-1:0]   a_radius, b_radius;
  logic [crp_pkg::MASS_W-1:0]  a_mass, b_mass;
  modport source (output valid, a_pos_x, a_pos_y, a_radius, a_mass,
                  b_pos_x, b_pos_y, b_radius, b_mass, input ready);
  modport sink (input valid, a_pos_x, a_pos_y, a_radius, a_mass,
                b_pos_x, b_pos_y, b_radius, b_mass, output ready);
endinterface

interface crp_out_if #(parameter int POS_WIDTH = crp_pkg::POS_WIDTH_DEF);
  logic valid;
  logic ready;
  logic signed [POS_WIDTH-1:0] new_a_x, new_a_y, new_b_x, new_b_y;
  logic       touching;
  logic [1:0] status;
  modport source (output valid, new_a_x, new_a_y, new_b_x, new_b_y, touching, status,
                  input ready);
  modport sink (input valid, new_a_x, new_a_y, new_b_x, new_b_y, touching, status,
                output ready);
endinterface

interface crp_cfg_if;
  logic valid;
  logic ready;
  logic [crp_pkg::DAMP_W-1:0] damping;
  modport source (output valid, damping, input ready);
  modport sink (input valid, damping, output ready);
endinterface

FILE: rtl/core/circle_pair_collision_resolver.sv
// Top level: mass-weighted separation of two overlapping circles, fully pipelined.
// Depends on crp_pkg, crp_if, crp_sqrt_cell and crp_div_cell.
//
//   port    dir   carries
//   in_ch   sink  pair request: positions, radii, masses of circles a and b
//   out_ch  src   result request: new positions, touching, status
//   cfg_ch  sink  damping write, always ready
//
// One pair accepted per cycle while the chain does not stall; stages: 3 prep stages, 18 root cells,
// 2 multiply stages, 33 share divider cells, 1 multiply stage, 19 move cells,
// output register. Synchronous reset clears the valid bits and loads damping.
// The chain stalls as a whole only while its last cell and the output register
// both hold results and out_ch.ready is low.
module circle_pair_collision_resolver #(
  parameter int POS_WIDTH = crp_pkg::POS_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  crp_in_if.sink    in_ch,
  crp_out_if.source out_ch,
  crp_cfg_if.sink   cfg_ch
);

  localparam int PW   = POS_WIDTH;
  localparam int CW   = (PW + 1 > crp_pkg::SUM_W) ? PW + 1 : crp_pkg::SUM_W;
  localparam int SW   = crp_pkg::SUM_W;
  localparam int MW   = crp_pkg::MASS_W;
  localparam int RW   = crp_pkg::ROOT_W;
  localparam int MSW  = crp_pkg::MSUM_W;
  localparam int SQW  = crp_pkg::SHARE_QW;
  localparam int SNW  = crp_pkg::SHARE_NW;
  localparam int MQW  = crp_pkg::MOVE_QW;
  localparam int MNW  = crp_pkg::MOVE_NW;
  localparam int MPW  = crp_pkg::MPROD_W;
  localparam int M2W  = crp_pkg::MSUM2_W;
  localparam int FR   = crp_pkg::DAMP_FRAC;
  localparam int EW   = ((PW > MQW + 1) ? PW : MQW + 1) + 2;
  localparam logic signed [EW-1:0] POS_HI = {{(EW-PW+1){1'b0}}, {(PW-1){1'b1}}};
  localparam logic signed [EW-1:0] POS_LO = {{(EW-PW+1){1'b1}}, {(PW-1){1'b0}}};

  typedef struct packed {
    logic signed [PW-1:0] ax, ay, bx, by;
  } pos_t;

  typedef struct packed {
    pos_t       p;
    logic       sx, sy, touch;
    logic [1:0] status;
  } base_t;

  typedef struct packed {
    pos_t                          p;
    logic [crp_pkg::RAD_W-1:0]     ra, rb;
    logic [MW-1:0]                 ma, mb;
  } s0_t;

  typedef struct packed {
    pos_t          p;
    logic          sx, sy, far;
    logic [SW-1:0] adx, ady, rsum;
    logic [MW-1:0] ma, mb;
  } s1_t;

  typedef struct packed {
    s1_t                         a;
    logic [crp_pkg::SQ_W-1:0]    sqx, sqy, r2;
  } s2_t;

  typedef struct packed {
    base_t         b;
    logic [SW-1:0] adx, ady, rsum;
    logic [MW-1:0] ma, mb;
  } sq_pt_t;

  typedef struct packed {
    base_t                       b;
    logic [SW-1:0]               adx, ady;
    logic [RW-1:0]               dlen;
    logic [MSW-1:0]              msum;
    logic [crp_pkg::PROD_W-1:0]  pa, pb;
  } s4_t;

  typedef struct packed {
    base_t                       b;
    logic [SW-1:0]               adx, ady;
    logic [RW-1:0]               dlen;
    logic [MSW-1:0]              msum;
    logic [crp_pkg::TERM_W-1:0]  ta, tb;
  } s5_t;

  typedef struct packed {
    base_t         b;
    logic [SW-1:0] adx, ady;
    logic [RW-1:0] dlen;
  } dv_pt_t;

  typedef struct packed {
    base_t          b;
    logic [RW-1:0]  dlen;
    logic [MPW-1:0] mxa, mya, mxb, myb;
  } s6_t;

  function automatic logic signed [PW-1:0] apply_move(logic signed [PW-1:0] p, logic neg,
                                                      logic [MQW-1:0] mv);
    logic signed [EW-1:0] m;
    logic signed [EW-1:0] s;
    m = EW'(mv);
    if (neg) begin
      m = -m;
    end
    s = EW'(p) + m;
    if (s > POS_HI) begin
      return POS_HI[PW-1:0];
    end else if (s < POS_LO) begin
      return POS_LO[PW-1:0];
    end
    return s[PW-1:0];
  endfunction

  logic adv;
  logic out_valid_r;
  logic [crp_pkg::DAMP_W-1:0] damping_r;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damping_r <= crp_pkg::DAMP_RESET;
    end else if (cfg_ch.valid) begin
      damping_r <= cfg_ch.damping;
    end
  end

  // stage 0: input register
  logic s0_v_r;
  s0_t  s0_r;

  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (adv) begin
      s0_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r.p.ax <= in_ch.a_pos_x;
      s0_r.p.ay <= in_ch.a_pos_y;
      s0_r.p.bx <= in_ch.b_pos_x;
      s0_r.p.by <= in_ch.b_pos_y;
      s0_r.ra   <= in_ch.a_radius;
      s0_r.rb   <= in_ch.b_radius;
      s0_r.ma   <= in_ch.a_mass;
      s0_r.mb   <= in_ch.b_mass;
    end
  end

  // stage 1: differences, far test
  logic signed [PW:0] dx, dy;
  logic [PW:0]        adx_f, ady_f;
  logic [CW-1:0]      adx_w, ady_w, rsum_w;
  logic [SW-1:0]      rsum0;
  s1_t                s1_nxt, s1_r;
  logic               s1_v_r;

  always_comb begin
    dx     = (PW+1)'(s0_r.p.ax) - (PW+1)'(s0_r.p.bx);
    dy     = (PW+1)'(s0_r.p.ay) - (PW+1)'(s0_r.p.by);
    adx_f  = dx[PW] ? -dx : dx;
    ady_f  = dy[PW] ? -dy : dy;
    adx_w  = CW'(adx_f);
    ady_w  = CW'(ady_f);
    rsum0  = SW'(s0_r.ra) + SW'(s0_r.rb);
    rsum_w = CW'(rsum0);
    s1_nxt.p    = s0_r.p;
    s1_nxt.sx   = dx[PW];
    s1_nxt.sy   = dy[PW];
    s1_nxt.far  = (adx_w > rsum_w) || (ady_w > rsum_w);
    s1_nxt.adx  = adx_w[SW-1:0];
    s1_nxt.ady  = ady_w[SW-1:0];
    s1_nxt.rsum = rsum0;
    s1_nxt.ma   = s0_r.ma;
    s1_nxt.mb   = s0_r.mb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= s0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  // stage 2: squares
  logic s2_v_r;
  s2_t  s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r.a   <= s1_r;
      s2_r.sqx <= crp_pkg::SQ_W'(s1_r.adx) * crp_pkg::SQ_W'(s1_r.adx);
      s2_r.sqy <= crp_pkg::SQ_W'(s1_r.ady) * crp_pkg::SQ_W'(s1_r.ady);
      s2_r.r2  <= crp_pkg::SQ_W'(s1_r.rsum) * crp_pkg::SQ_W'(s1_r.rsum);
    end
  end

  // classification, then square root chain
  logic [crp_pkg::D2_W-1:0] d2;
  sq_pt_t                   sq_in;

  always_comb begin
    d2 = crp_pkg::D2_W'(s2_r.sqx) + crp_pkg::D2_W'(s2_r.sqy);
    sq_in.b.p     = s2_r.a.p;
    sq_in.b.sx    = s2_r.a.sx;
    sq_in.b.sy    = s2_r.a.sy;
    sq_in.b.touch = !s2_r.a.far && (d2 <= crp_pkg::D2_W'(s2_r.r2));
    priority if (s2_r.a.far || d2 >= crp_pkg::D2_W'(s2_r.r2)) begin
      sq_in.b.status = crp_pkg::ST_NONE;
    end else if (d2 == '0) begin
      sq_in.b.status = crp_pkg::ST_COIN;
    end else begin
      sq_in.b.status = crp_pkg::ST_SEP;
    end
    sq_in.adx  = s2_r.a.adx;
    sq_in.ady  = s2_r.a.ady;
    sq_in.rsum = s2_r.a.rsum;
    sq_in.ma   = s2_r.a.ma;
    sq_in.mb   = s2_r.a.mb;
  end

  logic              sq_v    [0:RW];
  logic [RW+1:0]     sq_rem  [0:RW];
  logic [RW-1:0]     sq_root [0:RW];
  logic [2*RW-1:0]   sq_rad  [0:RW];
  logic [$bits(sq_pt_t)-1:0] sq_pt [0:RW];

  assign sq_v[0]    = s2_v_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_rad[0]  = (2*RW)'(d2);
  assign sq_pt[0]   = sq_in;

  genvar g;
  for (g = 0; g < RW; g++) begin : g_sq
    crp_sqrt_cell #(.ROOT_W(RW), .PT_W($bits(sq_pt_t))) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .v_i(sq_v[g]), .rem_i(sq_rem[g]), .root_i(sq_root[g]), .rad_i(sq_rad[g]),
      .pt_i(sq_pt[g]),
      .v_o(sq_v[g+1]), .rem_o(sq_rem[g+1]), .root_o(sq_root[g+1]), .rad_o(sq_rad[g+1]),
      .pt_o(sq_pt[g+1])
    );
  end

  // stage 4: overlap times masses
  sq_pt_t        sq_out;
  logic [RW-1:0] ov_full;
  logic [SW-1:0] overlap;
  logic [MW-1:0] ma_f, mb_f;
  logic          s4_v_r;
  s4_t           s4_r;

  always_comb begin
    sq_out  = sq_pt[RW];
    ov_full = RW'(sq_out.rsum) - sq_root[RW];
    overlap = ov_full[SW-1:0];
    if (sq_out.ma == '0 && sq_out.mb == '0) begin
      ma_f = MW'(1);
      mb_f = MW'(1);
    end else begin
      ma_f = sq_out.ma;
      mb_f = sq_out.mb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= sq_v[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_r.b    <= sq_out.b;
      s4_r.adx  <= sq_out.adx;
      s4_r.ady  <= sq_out.ady;
      s4_r.dlen <= sq_root[RW];
      s4_r.msum <= MSW'(ma_f) + MSW'(mb_f);
      s4_r.pa   <= crp_pkg::PROD_W'(overlap) * crp_pkg::PROD_W'(mb_f);
      s4_r.pb   <= crp_pkg::PROD_W'(overlap) * crp_pkg::PROD_W'(ma_f);
    end
  end

  // stage 5: times damping
  logic s5_v_r;
  s5_t  s5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_r.b    <= s4_r.b;
      s5_r.adx  <= s4_r.adx;
      s5_r.ady  <= s4_r.ady;
      s5_r.dlen <= s4_r.dlen;
      s5_r.msum <= s4_r.msum;
      s5_r.ta   <= crp_pkg::TERM_W'(s4_r.pa) * crp_pkg::TERM_W'(damping_r);
      s5_r.tb   <= crp_pkg::TERM_W'(s4_r.pb) * crp_pkg::TERM_W'(damping_r);
    end
  end

  // share divider chain, rounded half up
  logic [SNW-1:0] na, nb;
  dv_pt_t         d1_in;

  always_comb begin
    na = SNW'(s5_r.ta) + SNW'(s5_r.msum >> 1);
    nb = SNW'(s5_r.tb) + SNW'(s5_r.msum >> 1);
    d1_in.b    = s5_r.b;
    d1_in.adx  = s5_r.adx;
    d1_in.ady  = s5_r.ady;
    d1_in.dlen = s5_r.dlen;
  end

  logic                       d1_v   [0:SQW];
  logic [MSW-1:0]             d1_d   [0:SQW];
  logic [1:0][MSW-1:0]        d1_rem [0:SQW];
  logic [1:0][SQW-1:0]        d1_nq  [0:SQW];
  logic [$bits(dv_pt_t)-1:0]  d1_pt  [0:SQW];

  assign d1_v[0]      = s5_v_r;
  assign d1_d[0]      = s5_r.msum;
  assign d1_rem[0][0] = na[SNW-1 -: MSW];
  assign d1_rem[0][1] = nb[SNW-1 -: MSW];
  assign d1_nq[0][0]  = na[SQW-1:0];
  assign d1_nq[0][1]  = nb[SQW-1:0];
  assign d1_pt[0]     = d1_in;

  for (g = 0; g < SQW; g++) begin : g_d1
    crp_div_cell #(.LANES(2), .DIV_W(MSW), .QUO_W(SQW), .PT_W($bits(dv_pt_t))) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .v_i(d1_v[g]), .d_i(d1_d[g]), .rem_i(d1_rem[g]), .nq_i(d1_nq[g]), .pt_i(d1_pt[g]),
      .v_o(d1_v[g+1]), .d_o(d1_d[g+1]), .rem_o(d1_rem[g+1]), .nq_o(d1_nq[g+1]),
      .pt_o(d1_pt[g+1])
    );
  end

  // stage 6: axis components times shares
  dv_pt_t         d1_out;
  logic [SQW-1:0] share_a, share_b;
  logic           s6_v_r;
  s6_t            s6_r;

  always_comb begin
    d1_out  = d1_pt[SQW];
    share_a = d1_nq[SQW][0];
    share_b = d1_nq[SQW][1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s6_v_r <= d1_v[SQW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_r.b    <= d1_out.b;
      s6_r.dlen <= d1_out.dlen;
      s6_r.mxa  <= MPW'(d1_out.adx) * MPW'(share_a);
      s6_r.mya  <= MPW'(d1_out.ady) * MPW'(share_a);
      s6_r.mxb  <= MPW'(d1_out.adx) * MPW'(share_b);
      s6_r.myb  <= MPW'(d1_out.ady) * MPW'(share_b);
    end
  end

  // move divider chain: (m + dist*2^14) / (dist*2^15), low bits dropped first
  logic [3:0][M2W-1:0] mnum;
  logic [3:0][MNW-1:0] mq;

  always_comb begin
    mnum[0] = M2W'(s6_r.mxa) + (M2W'(s6_r.dlen) << (FR - 1));
    mnum[1] = M2W'(s6_r.mya) + (M2W'(s6_r.dlen) << (FR - 1));
    mnum[2] = M2W'(s6_r.mxb) + (M2W'(s6_r.dlen) << (FR - 1));
    mnum[3] = M2W'(s6_r.myb) + (M2W'(s6_r.dlen) << (FR - 1));
    for (int l = 0; l < 4; l++) begin
      mq[l] = mnum[l][FR +: MNW];
    end
  end

  logic                      d2_v   [0:MQW];
  logic [RW-1:0]             d2_d   [0:MQW];
  logic [3:0][RW-1:0]        d2_rem [0:MQW];
  logic [3:0][MQW-1:0]       d2_nq  [0:MQW];
  logic [$bits(base_t)-1:0]  d2_pt  [0:MQW];

  assign d2_v[0]  = s6_v_r;
  assign d2_d[0]  = s6_r.dlen;
  assign d2_pt[0] = s6_r.b;

  for (g = 0; g < 4; g++) begin : g_d2_ld
    assign d2_rem[0][g] = mq[g][MNW-1 -: RW];
    assign d2_nq[0][g]  = mq[g][MQW-1:0];
  end

  for (g = 0; g < MQW; g++) begin : g_d2
    crp_div_cell #(.LANES(4), .DIV_W(RW), .QUO_W(MQW), .PT_W($bits(base_t))) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .v_i(d2_v[g]), .d_i(d2_d[g]), .rem_i(d2_rem[g]), .nq_i(d2_nq[g]), .pt_i(d2_pt[g]),
      .v_o(d2_v[g+1]), .d_o(d2_d[g+1]), .rem_o(d2_rem[g+1]), .nq_o(d2_nq[g+1]),
      .pt_o(d2_pt[g+1])
    );
  end

  // final update and output register
  base_t fin;
  pos_t  fin_p;

  always_comb begin
    fin = d2_pt[MQW];
    if (fin.status == crp_pkg::ST_SEP) begin
      fin_p.ax = apply_move(fin.p.ax, fin.sx, d2_nq[MQW][0]);
      fin_p.ay = apply_move(fin.p.ay, fin.sy, d2_nq[MQW][1]);
      fin_p.bx = apply_move(fin.p.bx, !fin.sx, d2_nq[MQW][2]);
      fin_p.by = apply_move(fin.p.by, !fin.sy, d2_nq[MQW][3]);
    end else begin
      fin_p = fin.p;
    end
  end

  assign adv = !d2_v[MQW] || !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && d2_v[MQW]) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  pos_t       out_p_r;
  logic       out_touch_r;
  logic [1:0] out_status_r;

  always_ff @(posedge clk) begin
    if (adv && d2_v[MQW]) begin
      out_p_r      <= fin_p;
      out_touch_r  <= fin.touch;
      out_status_r <= fin.status;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.new_a_x  = out_p_r.ax;
  assign out_ch.new_a_y  = out_p_r.ay;
  assign out_ch.new_b_x  = out_p_r.bx;
  assign out_ch.new_b_y  = out_p_r.by;
  assign out_ch.touching = out_touch_r;
  assign out_ch.status   = out_status_r;

endmodule

FILE: rtl/core/crp_sqrt_cell.sv
// One digit cell of the pipelined integer square root (two radicand bits per cell).
// Uses no package; instantiated in a chain by the top level.
module crp_sqrt_cell #(
  parameter int ROOT_W = 18,
  parameter int PT_W   = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  v_i,
  input  logic [ROOT_W+1:0]     rem_i,
  input  logic [ROOT_W-1:0]     root_i,
  input  logic [2*ROOT_W-1:0]   rad_i,
  input  logic [PT_W-1:0]       pt_i,
  output logic                  v_o,
  output logic [ROOT_W+1:0]     rem_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [2*ROOT_W-1:0]   rad_o,
  output logic [PT_W-1:0]       pt_o
);

  logic                v_r;
  logic [ROOT_W+1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [2*ROOT_W-1:0] rad_r, rad_nxt;
  logic [PT_W-1:0]     pt_r;
  logic [ROOT_W+3:0]   rem2, trial, diff;
  logic                ge;

  always_comb begin
    rem2     = {rem_i, rad_i[2*ROOT_W-1 -: 2]};
    trial    = {2'b00, root_i, 2'b01};
    diff     = rem2 - trial;
    ge       = (rem2 >= trial);
    rem_nxt  = ge ? diff[ROOT_W+1:0] : rem2[ROOT_W+1:0];
    root_nxt = {root_i[ROOT_W-2:0], ge};
    rad_nxt  = {rad_i[2*ROOT_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      rad_r  <= rad_nxt;
      pt_r   <= pt_i;
    end
  end

  assign v_o    = v_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;
  assign pt_o   = pt_r;

endmodule

FILE: rtl/core/crp_div_cell.sv
// One quotient bit cell of a pipelined restoring divider, several lanes on one divisor.
// Uses no package; instantiated in chains by the top level.
module crp_div_cell #(
  parameter int LANES = 2,
  parameter int DIV_W = 17,
  parameter int QUO_W = 33,
  parameter int PT_W  = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          v_i,
  input  logic [DIV_W-1:0]              d_i,
  input  logic [LANES-1:0][DIV_W-1:0]   rem_i,
  input  logic [LANES-1:0][QUO_W-1:0]   nq_i,
  input  logic [PT_W-1:0]               pt_i,
  output logic                          v_o,
  output logic [DIV_W-1:0]              d_o,
  output logic [LANES-1:0][DIV_W-1:0]   rem_o,
  output logic [LANES-1:0][QUO_W-1:0]   nq_o,
  output logic [PT_W-1:0]               pt_o
);

  logic                        v_r;
  logic [DIV_W-1:0]            d_r;
  logic [LANES-1:0][DIV_W-1:0] rem_r, rem_nxt;
  logic [LANES-1:0][QUO_W-1:0] nq_r, nq_nxt;
  logic [PT_W-1:0]             pt_r;

  always_comb begin
    logic [DIV_W:0] rem2;
    logic [DIV_W:0] diff;
    logic           ge;
    for (int l = 0; l < LANES; l++) begin
      rem2       = {rem_i[l], nq_i[l][QUO_W-1]};
      diff       = rem2 - {1'b0, d_i};
      ge         = (rem2 >= {1'b0, d_i});
      rem_nxt[l] = ge ? diff[DIV_W-1:0] : rem2[DIV_W-1:0];
      nq_nxt[l]  = {nq_i[l][QUO_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r   <= d_i;
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
      pt_r  <= pt_i;
    end
  end

  assign v_o   = v_r;
  assign d_o   = d_r;
  assign rem_o = rem_r;
  assign nq_o  = nq_r;
  assign pt_o  = pt_r;

endmodule
